// ----- sv/lens_focus_step_planner_assert.svh -----
// assertion macros for the planner rtl
`ifndef LENS_FOCUS_STEP_PLANNER_ASSERT_SVH
`define LENS_FOCUS_STEP_PLANNER_ASSERT_SVH

`ifndef ASSERT_OFF
`define LFSP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lfsp assertion failed");
`define LFSP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lfsp assertion failed");
`else
`define LFSP_ASSERT_IMP(lbl, ante, cons)
`define LFSP_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- sv/lfsp_pkg.sv -----
`timescale 1ns / 1ps
package lfsp_pkg;

  localparam int MAX_STEP_SIZES = 4;
  localparam int NUM_SIZE_REGS  = 4;
  localparam int SEARCH_FACTOR  = 10;

  localparam int POS_W  = 15;
  localparam int TGT_W  = 16;
  localparam int DIST_W = 16;
  localparam int CMD_W  = 4;
  localparam int IDX_W  = 2;
  localparam int N_W    = 3;
  localparam int ATT_W  = 6;
  localparam int MODE_W = 2;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int OUT_W  = 24;

  // register indexes
  localparam logic [2:0] REG_FOCUS_LIMIT  = 3'd0;
  localparam logic [2:0] REG_START_MODE   = 3'd1;
  localparam logic [2:0] REG_HANDS_OFF    = 3'd2;
  localparam logic [2:0] REG_STEPS_IN_USE = 3'd3;
  localparam logic [2:0] REG_STEP_SIZE_1  = 3'd4;
  localparam logic [2:0] REG_STEP_SIZE_2  = 3'd5;
  localparam logic [2:0] REG_STEP_SIZE_3  = 3'd6;
  localparam logic [2:0] REG_STEP_SIZE_4  = 3'd7;

  // start mode codes
  localparam logic [MODE_W-1:0] MODE_UNKNOWN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ALWAYS  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BIGGER  = 2'd2;

  typedef struct packed {
    logic [POS_W-1:0]                     focus_limit;
    logic [MODE_W-1:0]                    start_mode;
    logic                                 hands_off;
    logic [N_W-1:0]                       steps_in_use;
    logic [NUM_SIZE_REGS-1:0][POS_W-1:0]  step_len;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic init;
    logic rmove;
    logic settle;
    logic scan;
    logic smove;
    logic sdist;
    logic zero_out;
  } dp_cmd_t;

  typedef struct packed {
    logic do_reset;
    logic rmore;
    logic cont_first;
    logic cont_loop;
    logic cnt_zero;
    logic scan_done;
  } dp_sts_t;

endpackage

// ----- sv/lfsp_regs.sv -----
`timescale 1ns / 1ps
module lfsp_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lfsp_pkg::ADDR_W-1:0]   paddr,
  input  logic [lfsp_pkg::DATA_W-1:0]   pwdata,
  output logic [lfsp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output lfsp_pkg::cfg_t                cfg
);
  import lfsp_pkg::*;

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.focus_limit  <= 15'd32767;
      cfg.start_mode   <= MODE_UNKNOWN;
      cfg.hands_off    <= 1'b0;
      cfg.steps_in_use <= 3'd4;
      cfg.step_len[0]  <= 15'd1;
      cfg.step_len[1]  <= 15'd8;
      cfg.step_len[2]  <= 15'd64;
      cfg.step_len[3]  <= 15'd512;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FOCUS_LIMIT:  cfg.focus_limit  <= pwdata[POS_W-1:0];
        REG_START_MODE:   cfg.start_mode   <= pwdata[MODE_W-1:0];
        REG_HANDS_OFF:    cfg.hands_off    <= pwdata[0];
        REG_STEPS_IN_USE: cfg.steps_in_use <= pwdata[N_W-1:0];
        REG_STEP_SIZE_1:  cfg.step_len[0]  <= pwdata[POS_W-1:0];
        REG_STEP_SIZE_2:  cfg.step_len[1]  <= pwdata[POS_W-1:0];
        REG_STEP_SIZE_3:  cfg.step_len[2]  <= pwdata[POS_W-1:0];
        REG_STEP_SIZE_4:  cfg.step_len[3]  <= pwdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FOCUS_LIMIT:  prdata = DATA_W'(cfg.focus_limit);
      REG_START_MODE:   prdata = DATA_W'(cfg.start_mode);
      REG_HANDS_OFF:    prdata = DATA_W'(cfg.hands_off);
      REG_STEPS_IN_USE: prdata = DATA_W'(cfg.steps_in_use);
      REG_STEP_SIZE_1:  prdata = DATA_W'(cfg.step_len[0]);
      REG_STEP_SIZE_2:  prdata = DATA_W'(cfg.step_len[1]);
      REG_STEP_SIZE_3:  prdata = DATA_W'(cfg.step_len[2]);
      REG_STEP_SIZE_4:  prdata = DATA_W'(cfg.step_len[3]);
      default:          prdata = '0;
    endcase
  end

endmodule

// ----- sv/lfsp_dp.sv -----
`timescale 1ns / 1ps
module lfsp_dp #(
  parameter int MAX_MOVES = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lfsp_pkg::cfg_t              cfg,
  input  lfsp_pkg::dp_cmd_t           cmd,
  output lfsp_pkg::dp_sts_t           sts,
  input  logic [lfsp_pkg::TGT_W-1:0]  target_in,
  output logic [lfsp_pkg::CMD_W-1:0]  step_command,
  output logic [lfsp_pkg::POS_W-1:0]  position_after
);
  import lfsp_pkg::*;

  localparam int CNT_W = $clog2(MAX_MOVES + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_MOVES);
  localparam int SPOS_W = POS_W + 3;

  // tracked position and request state
  logic              known;
  logic [POS_W-1:0]  pos;
  logic [TGT_W-1:0]  target;
  logic [POS_W-1:0]  rem;
  logic [CNT_W-1:0]  cnt;
  logic [ATT_W-1:0]  attempts;
  logic [DIST_W-1:0] remaining;
  logic [IDX_W-1:0]  best;
  logic [DIST_W-1:0] bestd;
  logic [IDX_W-1:0]  scan_k;
  logic              rmore;
  logic [POS_W-1:0]  last_start;
  logic [DIST_W-1:0] last_dist;
  logic [CMD_W-1:0]  out_cmd;
  logic [POS_W-1:0]  out_pos;

  logic [N_W-1:0]                      n_eff;
  logic [IDX_W-1:0]                    n_idx;
  logic [NUM_SIZE_REGS-1:0][POS_W-1:0] size_eff;
  logic [POS_W-1:0]                    largest;
  logic [POS_W-1:0]                    smallest;
  logic [ATT_W-1:0]                    att_lim;
  logic signed [SPOS_W-1:0]            cur_s;
  logic [DIST_W-1:0]                   focus_diff;
  logic [POS_W-1:0]                    f_start;
  logic [POS_W-1:0]                    span;
  logic [DIST_W-1:0]                   dist_new;
  logic [DIST_W-1:0]                   scan_d;
  logic [POS_W-1:0]                    rmove_pos;
  logic [POS_W-1:0]                    smove_pos;
  logic                                down;
  logic [CMD_W-1:0]                    smag;
  logic [CNT_W-1:0]                    cnt_inc;

  function automatic logic [DIST_W-1:0] abs_diff(input logic [DIST_W-1:0] a,
                                                 input logic [DIST_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // one move from cur by size, clamped to 0..limit
  function automatic logic [POS_W-1:0] step_to(input logic signed [SPOS_W-1:0] cur,
                                               input logic [POS_W-1:0] size,
                                               input logic dn,
                                               input logic [POS_W-1:0] limit);
    logic signed [SPOS_W-1:0] sz;
    logic signed [SPOS_W-1:0] p;
    sz = $signed({3'b000, size});
    p  = dn ? cur - sz : cur + sz;
    if (p < 0) begin
      return '0;
    end else if (p > $signed({3'b000, limit})) begin
      return limit;
    end else begin
      return p[POS_W-1:0];
    end
  endfunction

  always_comb begin
    if (cfg.steps_in_use == '0) begin
      n_eff = N_W'(1);
    end else if (cfg.steps_in_use > N_W'(MAX_STEP_SIZES)) begin
      n_eff = N_W'(MAX_STEP_SIZES);
    end else begin
      n_eff = cfg.steps_in_use;
    end
  end

  assign n_idx = IDX_W'(n_eff - N_W'(1));

  // a zero step size acts as one
  always_comb begin
    for (int k = 0; k < NUM_SIZE_REGS; k++) begin
      size_eff[k] = (cfg.step_len[k] == '0) ? POS_W'(1) : cfg.step_len[k];
    end
  end

  assign largest  = size_eff[n_idx];
  assign smallest = size_eff[0];
  assign att_lim  = ATT_W'({n_eff, 3'b000}) + ATT_W'({n_eff, 1'b0});
  assign cur_s    = known ? $signed({3'b000, pos}) : -SPOS_W'(1);
  assign cnt_inc  = cnt + CNT_W'(1);

  assign focus_diff = abs_diff({1'b0, last_start}, target);
  assign f_start    = (cfg.hands_off && known) ? pos : '0;
  assign span       = (cfg.focus_limit > f_start) ? cfg.focus_limit - f_start : '0;
  assign dist_new   = abs_diff({1'b0, pos}, target);
  assign scan_d     = abs_diff(remaining, {1'b0, size_eff[scan_k]});

  assign rmove_pos = step_to(cur_s, largest, 1'b0, cfg.focus_limit);
  assign down      = target < {1'b0, pos};
  assign smove_pos = step_to(cur_s, size_eff[best], down, cfg.focus_limit);
  assign smag      = CMD_W'(best) + CMD_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      known      <= 1'b0;
      last_start <= '0;
      last_dist  <= '0;
    end else begin
      if (cmd.rmove || cmd.smove) begin
        known <= 1'b1;
      end
      if (cmd.settle) begin
        last_start <= pos;
        last_dist  <= dist_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      target   <= target_in;
      cnt      <= '0;
      attempts <= '0;
    end
    if (cmd.init) begin
      rem <= span;
    end
    if (cmd.rmove) begin
      pos     <= rmove_pos;
      rem     <= rem - largest;
      cnt     <= cnt_inc;
      rmore   <= (rem >= largest) && (cnt_inc < MAX_CNT);
      out_cmd <= CMD_W'(n_eff);
      out_pos <= rmove_pos;
    end
    if (cmd.settle || cmd.sdist) begin
      remaining <= dist_new;
    end
    if (cmd.scan) begin
      if (scan_k == '0 || scan_d < bestd) begin
        best  <= scan_k;
        bestd <= scan_d;
      end
      scan_k <= scan_k + IDX_W'(1);
    end else begin
      scan_k <= '0;
    end
    if (cmd.smove) begin
      pos      <= smove_pos;
      cnt      <= cnt_inc;
      attempts <= attempts + ATT_W'(1);
      out_cmd  <= down ? CMD_W'(0) - smag : smag;
      out_pos  <= smove_pos;
    end
    if (cmd.zero_out) begin
      out_cmd <= '0;
      out_pos <= pos;
    end
  end

  // the loop check runs while the distance register is being refreshed
  always_comb begin
    sts.do_reset   = !known || (pos > cfg.focus_limit)
                     || (cfg.start_mode == MODE_ALWAYS)
                     || ((cfg.start_mode == MODE_BIGGER) && (focus_diff > last_dist));
    sts.rmore      = rmore;
    sts.cont_first = (remaining > {1'b0, smallest}) && (cnt < MAX_CNT);
    sts.cont_loop  = (dist_new >= {1'b0, smallest}) && (attempts < att_lim)
                     && (cnt < MAX_CNT);
    sts.cnt_zero   = (cnt == '0);
    sts.scan_done  = (scan_k == n_idx);
  end

  assign step_command   = out_cmd;
  assign position_after = out_pos;

endmodule

// ----- sv/lfsp_ctrl.sv -----
`timescale 1ns / 1ps
module lfsp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic                m_tlast,
  input  lfsp_pkg::dp_sts_t   sts,
  output lfsp_pkg::dp_cmd_t   cmd
);
  import lfsp_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_DECIDE = 12'b000000000010,
    S_RMOVE  = 12'b000000000100,
    S_RNEXT  = 12'b000000001000,
    S_ROUT   = 12'b000000010000,
    S_SETTLE = 12'b000000100000,
    S_FCHK   = 12'b000001000000,
    S_SOUT   = 12'b000010000000,
    S_SCAN   = 12'b000100000000,
    S_SMOVE  = 12'b001000000000,
    S_SDIST  = 12'b010000000000,
    S_LOUT   = 12'b100000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // the held word goes out as soon as the next move is known to follow
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (s_tvalid) state_next = S_DECIDE;
      S_DECIDE: state_next = sts.do_reset ? S_RMOVE : S_SETTLE;
      S_RMOVE:  state_next = S_RNEXT;
      S_RNEXT:  state_next = sts.rmore ? S_ROUT : S_SETTLE;
      S_ROUT:   if (m_tready) state_next = S_RMOVE;
      S_SETTLE: state_next = S_FCHK;
      S_FCHK: begin
        if (sts.cont_first) begin
          state_next = sts.cnt_zero ? S_SCAN : S_SOUT;
        end else begin
          state_next = S_LOUT;
        end
      end
      S_SOUT:   if (m_tready) state_next = S_SCAN;
      S_SCAN:   if (sts.scan_done) state_next = S_SMOVE;
      S_SMOVE:  state_next = S_SDIST;
      S_SDIST:  state_next = sts.cont_loop ? S_SOUT : S_LOUT;
      S_LOUT:   if (m_tready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.load_in  = (state == S_IDLE) && s_tvalid;
    cmd.init     = (state == S_DECIDE);
    cmd.rmove    = (state == S_RMOVE);
    cmd.settle   = (state == S_SETTLE);
    cmd.scan     = (state == S_SCAN);
    cmd.smove    = (state == S_SMOVE);
    cmd.sdist    = (state == S_SDIST);
    cmd.zero_out = (state == S_FCHK) && !sts.cont_first && sts.cnt_zero;
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_ROUT) || (state == S_SOUT) || (state == S_LOUT);
  assign m_tlast  = (state == S_LOUT);

endmodule

// ----- sv/lens_focus_step_planner.sv -----
`timescale 1ns / 1ps
// lens focus step planner
// s_tdata carries one target focus position; for each target the block sends
// one or more words on m_tdata, each a signed step command with the tracked
// position after it, m_tlast marking the final word of the request. a request
// that needs no move gives a single word with step command zero.
// registers are written over the apb port; the user must write them only
// while the block is idle, the block itself does not enforce it. one request
// at a time: s_tready is high only while idle. after acceptance a reset run
// (repeated largest steps) moves, checks for more and outputs a word for each
// move, and each search move scans the step sizes in use (1 to 4), makes the
// move, updates the distance and outputs the word; any output waits while the
// receiver holds m_tready low. up to MAX_MOVES words per request.
// a word waits in the output register until taken; nothing else advances
// while m_tready is low.
// reset leaves the focus position unknown and registers at their defaults,
// so the first request always begins with a reset run.
`include "lens_focus_step_planner_assert.svh"
module lens_focus_step_planner #(
  parameter int MAX_MOVES = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [15:0]                   s_tdata,   // [15:0] target_position
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [lfsp_pkg::OUT_W-1:0]    m_tdata,   // [3:0] step_command, [18:4] position_after
  output logic                          m_tlast,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lfsp_pkg::ADDR_W-1:0]   paddr,
  input  logic [lfsp_pkg::DATA_W-1:0]   pwdata,
  output logic [lfsp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import lfsp_pkg::*;

  cfg_t              cfg;
  dp_cmd_t           cmd;
  dp_sts_t           sts;
  logic [CMD_W-1:0]  step_command;
  logic [POS_W-1:0]  position_after;

  lfsp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lfsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .sts      (sts),
    .cmd      (cmd)
  );

  lfsp_dp #(
    .MAX_MOVES (MAX_MOVES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .sts            (sts),
    .target_in      (s_tdata[TGT_W-1:0]),
    .step_command   (step_command),
    .position_after (position_after)
  );

  assign m_tdata = {(OUT_W - POS_W - CMD_W)'(0), position_after, step_command};

  // no new request while a word is still waiting
  `LFSP_ASSERT_IMP(a_idle_no_word, s_tready, !m_tvalid)
  `LFSP_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  `LFSP_ASSERT_NXT(a_idle_after_last, m_tvalid && m_tready && m_tlast, s_tready)
  // every word but the final one is a real move
  `LFSP_ASSERT_IMP(a_move_not_zero, m_tvalid && !m_tlast, step_command != '0)

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import lfsp_pkg::*;

  localparam int MAX_MOVES = 64;
  // code 3 is not a defined start mode, the block treats it like unknown
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    logic             last;
  } move_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [15:0]         s_tdata = '0;    // [15:0] target_position
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_W-1:0]    m_tdata;         // [3:0] step_command, [18:4] position_after
  logic                m_tlast;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  lens_focus_step_planner #(.MAX_MOVES(MAX_MOVES)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // planner's copy of the registers and tracked state
  logic [POS_W-1:0]  limit_cfg = 15'd32767;
  logic [MODE_W-1:0] mode_cfg = MODE_UNKNOWN;
  logic              hands_cfg = 1'b0;
  logic [N_W-1:0]    steps_cfg = 3'd4;
  logic [POS_W-1:0]  step_cfg [NUM_SIZE_REGS] = '{15'd1, 15'd8, 15'd64, 15'd512};
  int                pos_est = -1;
  int                last_start = 0;
  int                last_dist = 0;

  move_t       req_buf [MAX_MOVES];
  int          req_cnt;
  move_t       planned_moves [$];
  logic [15:0] targets_pending [$];
  int          targets_sent = 0;
  int          targets_taken = 0;
  int          mismatches = 0;
  int          src_idle_pct = 30;
  int          snk_idle_pct = 85;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic int gap(input int a, input int b);
    return a > b ? a - b : b - a;
  endfunction

  function automatic int size_at(input int k);
    int v;
    if (k < 1) k = 1;
    if (k > MAX_STEP_SIZES) k = MAX_STEP_SIZES;
    v = int'(step_cfg[k-1]);
    return v == 0 ? 1 : v;
  endfunction

  function automatic void add_word(input int cmd);
    move_t w;
    w.cmd = 4'(cmd);
    w.pos = 15'(pos_est < 0 ? 0 : pos_est);
    w.last = 1'b0;
    req_buf[req_cnt] = w;
    req_cnt++;
  endfunction

  function automatic void step_motor(input int idx, input bit down);
    int p;
    p = down ? pos_est - size_at(idx) : pos_est + size_at(idx);
    if (p < 0) p = 0;
    if (p > int'(limit_cfg)) p = int'(limit_cfg);
    pos_est = p;
    add_word(down ? -idx : idx);
  endfunction

  function automatic void plan_moves(input logic [15:0] target_in);
    int  target, n, largest, smallest, remaining, f, span, runs, i, k;
    int  attempts, best, bestd, d;
    bit  homing;
    target = int'(target_in);
    n = int'(steps_cfg);
    if (n < 1) n = 1;
    if (n > MAX_STEP_SIZES) n = MAX_STEP_SIZES;
    largest = size_at(n);
    smallest = size_at(1);
    req_cnt = 0;
    homing = pos_est < 0 || pos_est > int'(limit_cfg) || mode_cfg == MODE_ALWAYS ||
             (mode_cfg == MODE_BIGGER && gap(last_start, target) > last_dist);
    if (homing) begin
      f = (hands_cfg && pos_est > 0) ? pos_est : 0;
      span = int'(limit_cfg) > f ? int'(limit_cfg) - f : 0;
      runs = span / largest + 1;
      for (i = 0; i < runs && req_cnt < MAX_MOVES; i++)
        step_motor(n, 1'b0);
    end
    last_start = pos_est & 'hFFFF;
    remaining = gap(pos_est, target);
    last_dist = remaining & 'hFFFF;
    if (remaining <= smallest) begin
      if (req_cnt == 0) add_word(0);
    end else begin
      attempts = 0;
      while (remaining >= smallest && attempts < n * SEARCH_FACTOR &&
             req_cnt < MAX_MOVES) begin
        attempts++;
        best = 1;
        bestd = gap(remaining, size_at(1));
        for (k = 2; k <= n; k++) begin
          d = gap(remaining, size_at(k));
          // strict compare keeps the smaller index on a tie
          if (d < bestd) begin
            best = k;
            bestd = d;
          end
        end
        step_motor(best, target < pos_est);
        remaining = gap(pos_est, target);
      end
    end
    req_buf[req_cnt-1].last = 1'b1;
    for (i = 0; i < req_cnt; i++)
      planned_moves = {planned_moves, req_buf[i]};
  endfunction

  // driver: one target word at a time from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        plan_moves(s_tdata);
        targets_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (targets_pending.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata <= targets_pending.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each taken word with the oldest planned move
  always @(posedge clk) begin
    move_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (planned_moves.size() == 0) begin
          report_mismatch("word with no move planned, tdata", int'(m_tdata), 0);
        end else begin
          want = planned_moves.pop_front();
          if (m_tdata[3:0] !== want.cmd)
            report_mismatch("step_command", int'(m_tdata[3:0]), int'(want.cmd));
          if (m_tdata[18:4] !== want.pos)
            report_mismatch("position_after", int'(m_tdata[18:4]), int'(want.pos));
          if (m_tlast !== want.last)
            report_mismatch("last", int'(m_tlast), int'(want.last));
        end
      end
      m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_FOCUS_LIMIT:  limit_cfg = val[POS_W-1:0];
      REG_START_MODE:   mode_cfg = val[MODE_W-1:0];
      REG_HANDS_OFF:    hands_cfg = val[0];
      REG_STEPS_IN_USE: steps_cfg = val[N_W-1:0];
      REG_STEP_SIZE_1:  step_cfg[0] = val[POS_W-1:0];
      REG_STEP_SIZE_2:  step_cfg[1] = val[POS_W-1:0];
      REG_STEP_SIZE_3:  step_cfg[2] = val[POS_W-1:0];
      REG_STEP_SIZE_4:  step_cfg[3] = val[POS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_sizes(input int s1, input int s2, input int s3, input int s4);
    cfg_write(REG_STEP_SIZE_1, DATA_W'(s1));
    cfg_write(REG_STEP_SIZE_2, DATA_W'(s2));
    cfg_write(REG_STEP_SIZE_3, DATA_W'(s3));
    cfg_write(REG_STEP_SIZE_4, DATA_W'(s4));
  endtask

  task automatic random_config();
    int r, i;
    logic [DATA_W-1:0] junk;
    logic [DATA_W-1:0] sz [NUM_SIZE_REGS];
    junk = DATA_W'($urandom) << 16;
    r = $urandom_range(9);
    case (r)
      0, 1:    cfg_write(REG_FOCUS_LIMIT, junk | 32767);
      2:       cfg_write(REG_FOCUS_LIMIT, junk | DATA_W'($urandom_range(0, 4)));
      3, 4, 5: cfg_write(REG_FOCUS_LIMIT, junk | DATA_W'($urandom_range(50, 3000)));
      default: cfg_write(REG_FOCUS_LIMIT, junk | DATA_W'($urandom_range(1, 32767)));
    endcase
    cfg_write(REG_START_MODE, (DATA_W'($urandom) << 16) | DATA_W'($urandom_range(3)));
    cfg_write(REG_HANDS_OFF, (DATA_W'($urandom) << 16) | DATA_W'($urandom_range(1)));
    r = $urandom_range(9);
    cfg_write(REG_STEPS_IN_USE, DATA_W'(r < 8 ? $urandom_range(1, 4) : $urandom_range(7)));
    r = $urandom_range(9);
    for (i = 0; i < NUM_SIZE_REGS; i++) begin
      case (r)
        0, 1, 2, 3, 4, 5: sz[i] = DATA_W'($urandom_range(1 << (3 * i), 3 << (3 * i)));
        6:                sz[i] = DATA_W'($urandom_range(0, 32767));
        7:                sz[i] = $urandom_range(1) ? 32767 : 0;
        default:          sz[i] = DATA_W'($urandom_range(0, 10));
      endcase
      sz[i] = sz[i] | (DATA_W'($urandom) << 16);
    end
    set_sizes(int'(sz[0]), int'(sz[1]), int'(sz[2]), int'(sz[3]));
  endtask

  task automatic queue_target(input int t);
    targets_pending = {targets_pending, 16'(t)};
    targets_sent++;
  endtask

  function automatic int pick_target(input int prev);
    int r, t;
    r = $urandom_range(99);
    if (r < 35) t = $urandom_range(0, int'(limit_cfg));
    else if (r < 60) t = prev + $urandom_range(0, 80) - 40;
    else if (r < 70) t = prev;
    else if (r < 78) t = $urandom_range(1) ? int'(limit_cfg) : 0;
    else if (r < 88) t = $urandom_range(int'(limit_cfg) + 1, 65535);
    else t = $urandom_range(0, 65535);
    if (t < 0) t = 0;
    if (t > 65535) t = 65535;
    return t;
  endfunction

  // wait for every planned move, then give the block time to settle
  task automatic drain();
    while (!(targets_taken == targets_sent && planned_moves.size() == 0))
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int ph, j, prev;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // defaults, position unknown after reset
    queue_target(0);
    queue_target(65535);
    queue_target(0);
    queue_target(32767);
    queue_target(32767);
    drain();

    // short travel, limit below the tracked position
    cfg_write(REG_FOCUS_LIMIT, 1000);
    cfg_write(REG_START_MODE, DATA_W'(MODE_UNKNOWN));
    cfg_write(REG_HANDS_OFF, 0);
    cfg_write(REG_STEPS_IN_USE, 4);
    set_sizes(1, 8, 64, 512);
    queue_target(100);
    queue_target(100);
    queue_target(136);
    queue_target(100);
    queue_target(1000);
    queue_target(0);
    queue_target(1001);
    queue_target(65535);
    drain();

    cfg_write(REG_START_MODE, DATA_W'(MODE_ALWAYS));
    cfg_write(REG_HANDS_OFF, 1);
    queue_target(500);
    queue_target(500);
    queue_target(0);
    drain();

    cfg_write(REG_START_MODE, DATA_W'(MODE_BIGGER));
    cfg_write(REG_HANDS_OFF, 0);
    queue_target(400);
    queue_target(420);
    queue_target(900);
    queue_target(905);
    drain();

    // spare mode code, no steps in use, zero smallest step, tiny limit
    cfg_write(REG_START_MODE, DATA_W'(MODE_SPARE));
    cfg_write(REG_STEPS_IN_USE, 0);
    cfg_write(REG_STEP_SIZE_1, 0);
    cfg_write(REG_FOCUS_LIMIT, 1);
    queue_target(1);
    queue_target(0);
    queue_target(5);
    drain();

    cfg_write(REG_STEPS_IN_USE, 7);
    cfg_write(REG_FOCUS_LIMIT, 32767);
    set_sizes(32767, 32767, 32767, 32767);
    queue_target(40000);
    queue_target(12);
    drain();

    prev = 0;
    for (ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin
        src_idle_pct = 85;
        snk_idle_pct = 30;
      end else if (ph == 6) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      random_config();
      for (j = 0; j < 27; j++) begin
        prev = pick_target(prev);
        queue_target(prev);
      end
      drain();
    end

    repeat (50) @(posedge clk);
    if (planned_moves.size() != 0)
      report_mismatch("moves still planned at end", planned_moves.size(), 0);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
